// ===== design/afe_pkg.sv =====
// ----------------------------------------------------------------------------
// afe_pkg
// Shared types and constants for the eased alpha fade animator.
// ----------------------------------------------------------------------------
package afe_pkg;

    localparam int DUR_W   = 15;
    localparam int LVL_W   = 8;
    localparam int CURVE_W = 2;
    localparam int TICK_W  = 16;
    localparam int NUM_W   = 2 * DUR_W;          // t*t or T*T
    localparam int PROD_W  = NUM_W + LVL_W;      // num * |end - start|
    localparam int MUL_W   = NUM_W + DUR_W;      // shared multiplier output
    localparam int Q_W     = LVL_W;              // quotient stays below 256
    localparam int BIT_W   = 3;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DURATION = 3'd0;
    localparam logic [2:0] REG_START    = 3'd1;
    localparam logic [2:0] REG_END      = 3'd2;
    localparam logic [2:0] REG_CURVE    = 3'd3;
    localparam logic [2:0] REG_LOOP     = 3'd4;

    localparam logic [CURVE_W-1:0] CURVE_LINEAR = 2'd0;
    localparam logic [CURVE_W-1:0] CURVE_QUAD   = 2'd1;
    localparam logic [CURVE_W-1:0] CURVE_REV    = 2'd2;

    localparam logic [DUR_W-1:0] DURATION_RST = 15'd30;
    localparam logic [LVL_W-1:0] START_RST    = 8'd0;
    localparam logic [LVL_W-1:0] END_RST      = 8'd255;

    typedef struct packed {
        logic [DUR_W-1:0]   duration;
        logic [LVL_W-1:0]   start_level;
        logic [LVL_W-1:0]   end_level;
        logic [CURVE_W-1:0] curve;
        logic               loop_mode;
    } afe_cfg_t;

    // one classified tick handed from front to back
    typedef struct packed {
        logic [DUR_W-1:0] t_max;
        logic [DUR_W-1:0] t_cur;
        logic             full;   // rate is 1: alpha is end_level
        logic             done;
    } afe_job_t;

endpackage

// ===== design/afe_front.sv =====
// ----------------------------------------------------------------------------
// afe_front
// Accepts ticks, advances the frame timer and classifies each tick into
// a curve length, a curve position, a full flag and a done flag.
// ----------------------------------------------------------------------------
module afe_front import afe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  afe_cfg_t cfg,
    input  logic     tick_valid,
    input  logic     clear,
    input  logic     q_full,
    output logic     push,
    output afe_job_t job
);

    logic [TICK_W-1:0] tick_count_reg;
    logic [TICK_W-1:0] tick_count_next;
    logic [TICK_W-1:0] tc0;
    logic [TICK_W-1:0] inc;
    logic [TICK_W-1:0] dur16;
    logic [TICK_W-1:0] tcn;
    logic [TICK_W-1:0] step_count;
    logic [DUR_W-1:0]  half;

    assign push = tick_valid && !q_full;

    always_comb
    begin
        tc0        = clear ? '0 : tick_count_reg;
        inc        = tc0 + 16'd1;
        dur16      = {1'b0, cfg.duration};
        half       = {1'b0, cfg.duration[DUR_W-1:1]};
        tcn        = inc;
        step_count = inc;
        job        = '0;
        if (!cfg.loop_mode)
        begin
            job.t_max = cfg.duration;
            if ((cfg.duration != '0) && (tc0 < dur16 - 16'd1))
            begin
                job.t_cur = inc[DUR_W-1:0];
            end
            else
            begin
                step_count = dur16;
                job.full   = 1'b1;
                job.done   = 1'b1;
            end
        end
        else
        begin
            if (inc >= dur16)
            begin
                tcn      = '0;
                job.done = 1'b1;
            end
            step_count = tcn;
            job.t_max  = half;
            // tcn never exceeds duration here, so the falling side stays non-negative
            if (tcn < {1'b0, half})
                job.t_cur = tcn[DUR_W-1:0];
            else
                job.t_cur = cfg.duration - tcn[DUR_W-1:0];
            job.full = (job.t_cur >= half);
        end
        tick_count_next = push ? step_count : tick_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_count_reg <= '0;
        else
            tick_count_reg <= tick_count_next;
    end

endmodule

// ===== design/afe_queue.sv =====
// ----------------------------------------------------------------------------
// afe_queue
// Two-entry queue of classified ticks between the front and the back.
// ----------------------------------------------------------------------------
module afe_queue import afe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  afe_job_t din,
    input  logic     pop,
    output afe_job_t dout,
    output logic     full,
    output logic     empty
);

    afe_job_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign dout  = mem_reg[rd_ptr_reg];
    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

// ===== design/afe_back.sv =====
// ----------------------------------------------------------------------------
// afe_back
// Evaluates the eased alpha for one classified tick: a shared multiplier
// forms num, den and num*|diff|, then a restoring divider takes one
// quotient bit per cycle. Result sits in an output register.
// ----------------------------------------------------------------------------
module afe_back import afe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  afe_cfg_t         cfg,
    input  logic             q_empty,
    input  afe_job_t         job,
    output logic             pop,
    input  logic             res_stall,
    output logic             res_valid,
    output logic [LVL_W-1:0] alpha,
    output logic             done_res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NUM  = 3'd1;
    localparam logic [2:0] ST_DEN  = 3'd2;
    localparam logic [2:0] ST_PROD = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]        state_reg, state_next;
    afe_job_t          job_reg, job_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  den_reg, den_next;
    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic              out_valid_reg, out_valid_next;
    logic [LVL_W-1:0]  alpha_reg, alpha_next;
    logic              done_reg, done_next;

    logic              square;
    logic              neg;
    logic [LVL_W-1:0]  mag;
    logic [DUR_W-1:0]  x;
    logic [NUM_W-1:0]  mul_a;
    logic [DUR_W-1:0]  mul_b;
    logic [MUL_W-1:0]  mul_p;
    logic [PROD_W-1:0] den_sh;
    logic              ge;
    logic [LVL_W:0]    qc;
    logic [LVL_W:0]    alpha_calc;
    logic              load;

    assign res_valid = out_valid_reg;
    assign alpha     = alpha_reg;
    assign done_res  = done_reg;

    always_comb
    begin
        square = cfg.curve inside {CURVE_QUAD, CURVE_REV};
        neg    = cfg.end_level < cfg.start_level;
        mag    = neg ? cfg.start_level - cfg.end_level : cfg.end_level - cfg.start_level;
        x      = (cfg.curve == CURVE_REV) ? job_reg.t_max - job_reg.t_cur : job_reg.t_cur;
        case (state_reg)
            ST_NUM:
            begin
                mul_a = {{(NUM_W-DUR_W){1'b0}}, x};
                mul_b = square ? x : {{(DUR_W-1){1'b0}}, 1'b1};
            end
            ST_DEN:
            begin
                mul_a = {{(NUM_W-DUR_W){1'b0}}, job_reg.t_max};
                mul_b = square ? job_reg.t_max : {{(DUR_W-1){1'b0}}, 1'b1};
            end
            default:
            begin
                mul_a = num_reg;
                mul_b = {{(DUR_W-LVL_W){1'b0}}, mag};
            end
        endcase
        mul_p  = {{DUR_W{1'b0}}, mul_a} * {{NUM_W{1'b0}}, mul_b};
        den_sh = {{LVL_W{1'b0}}, den_reg} << bit_reg;
        ge     = rem_reg >= den_sh;
        // floor of a negative quotient: round the magnitude up
        qc         = {1'b0, q_reg} + {{LVL_W{1'b0}}, (neg && (rem_reg != '0))};
        alpha_calc = neg ? {1'b0, cfg.start_level} - qc : {1'b0, cfg.start_level} + {1'b0, q_reg};
        load       = (state_reg == ST_FIN) && (!out_valid_reg || !res_stall);
        pop        = (state_reg == ST_IDLE) && !q_empty;

        state_next     = state_reg;
        job_next       = job_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        bit_next       = bit_reg;
        alpha_next     = alpha_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && res_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    job_next   = job;
                    state_next = job.full ? ST_FIN : ST_NUM;
                end
            end
            ST_NUM:
            begin
                num_next   = mul_p[NUM_W-1:0];
                state_next = ST_DEN;
            end
            ST_DEN:
            begin
                den_next   = mul_p[NUM_W-1:0];
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                rem_next   = mul_p[PROD_W-1:0];
                q_next     = '0;
                bit_next   = '1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - den_sh;
                    q_next   = q_reg | (Q_W'(1) << bit_reg);
                end
                bit_next = bit_reg - 3'd1;
                if (bit_reg == '0)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (load)
                begin
                    alpha_next     = job_reg.full ? cfg.end_level : alpha_calc[LVL_W-1:0];
                    done_next      = job_reg.done;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        bit_reg   <= bit_next;
        alpha_reg <= alpha_next;
        done_reg  <= done_next;
    end

endmodule

// ===== design/alpha_fade_easing_animator.sv =====
// ----------------------------------------------------------------------------
// alpha_fade_easing_animator
// Frame-timed alpha fade with linear, quadratic or reversed quadratic easing.
// ----------------------------------------------------------------------------
// Use:
//   Each word on the tick channel (tick_valid/tick_stall, field clear) is one
//   frame tick. For every tick exactly one word leaves on the result channel
//   (res_valid/res_stall, fields alpha and done_res), in order.
//   Registers sit on the APB port at 0x00 duration, 0x04 start_level,
//   0x08 end_level, 0x0C curve, 0x10 loop_mode; write them only while idle.
// Flow:
//   The front updates the timer in the accept cycle and queues the tick
//   (two entries). For an eased tick the back forms num, den and
//   num*|diff| on one shared multiplier, then runs eight restoring-divide steps,
//   then loads the output register; a tick at full rate goes straight to the
//   output register. The back takes the next tick only after it has finished the last.
// Reset:
//   rst_n clears the timer, the queue and the output valid; registers return
//   to duration 30, start 0, end 255, linear, one-shot.
// Stall:
//   A stalled result holds in the output register; the back finishes the
//   next tick and waits, and tick_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module alpha_fade_easing_animator import afe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              tick_valid,
    output logic              tick_stall,
    input  logic              clear,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [LVL_W-1:0]  alpha,
    output logic              done_res
);

    afe_cfg_t cfg_reg, cfg_next;
    logic     wr_en;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;
    afe_job_t job_in;
    afe_job_t job_out;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[4:2])
                REG_DURATION: cfg_next.duration    = pwdata[DUR_W-1:0];
                REG_START:    cfg_next.start_level = pwdata[LVL_W-1:0];
                REG_END:      cfg_next.end_level   = pwdata[LVL_W-1:0];
                REG_CURVE:    cfg_next.curve       = pwdata[CURVE_W-1:0];
                REG_LOOP:     cfg_next.loop_mode   = pwdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_DURATION: prdata = {{(DATA_W-DUR_W){1'b0}}, cfg_reg.duration};
            REG_START:    prdata = {{(DATA_W-LVL_W){1'b0}}, cfg_reg.start_level};
            REG_END:      prdata = {{(DATA_W-LVL_W){1'b0}}, cfg_reg.end_level};
            REG_CURVE:    prdata = {{(DATA_W-CURVE_W){1'b0}}, cfg_reg.curve};
            REG_LOOP:     prdata = {{(DATA_W-1){1'b0}}, cfg_reg.loop_mode};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duration    <= DURATION_RST;
            cfg_reg.start_level <= START_RST;
            cfg_reg.end_level   <= END_RST;
            cfg_reg.curve       <= CURVE_LINEAR;
            cfg_reg.loop_mode   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign tick_stall = q_full;

    afe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .tick_valid (tick_valid),
        .clear      (clear),
        .q_full     (q_full),
        .push       (push),
        .job        (job_in)
    );

    afe_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (job_in),
        .pop   (pop),
        .dout  (job_out),
        .full  (q_full),
        .empty (q_empty)
    );

    afe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .job       (job_out),
        .pop       (pop),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .alpha     (alpha),
        .done_res  (done_res)
    );

endmodule

// ===== design/afe_checker.sv =====
// ----------------------------------------------------------------------------
// afe_checker
// Port-level checks for the alpha fade animator, bound to the top level.
// ----------------------------------------------------------------------------
module afe_checker import afe_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready,
    input logic              tick_valid,
    input logic              tick_stall,
    input logic              clear,
    input logic              res_valid,
    input logic              res_stall,
    input logic [LVL_W-1:0]  alpha,
    input logic              done_res
);

    // a stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(alpha) && $stable(done_res))
        else $error("result word changed while stalled");

    // a stalled tick word holds
    a_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_stall |=> tick_valid && $stable(clear))
        else $error("tick word changed while stalled");

    // no result is offered right after a reset cycle
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !res_valid)
        else $error("result valid during reset");

    // a written duration reads back
    a_dur_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[4:2] == REG_DURATION)
        ##1 (paddr[4:2] == REG_DURATION)
        |-> prdata[DUR_W-1:0] == $past(pwdata[DUR_W-1:0]))
        else $error("duration readback mismatch");

    // written start level reads back
    a_start_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[4:2] == REG_START)
        ##1 (paddr[4:2] == REG_START)
        |-> prdata[LVL_W-1:0] == $past(pwdata[LVL_W-1:0]))
        else $error("start level readback mismatch");

endmodule

bind alpha_fade_easing_animator afe_checker u_afe_checker (.*);
